FILE: design/ethernet_ipv4_header_parser_defines.svh
// Assertion macros for the Ethernet/IPv4 header parser.
`ifndef ETHERNET_IPV4_HEADER_PARSER_DEFINES_SVH
`define ETHERNET_IPV4_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define EIHP_ASSERT_NOW(name, clk_s, rst_s, pre, post, msg) \
    name: assert property (@(posedge clk_s) disable iff (!(rst_s)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define EIHP_ASSERT_NEXT(name, clk_s, rst_s, pre, post, msg) \
    name: assert property (@(posedge clk_s) disable iff (!(rst_s)) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: design/eihp_pkg.sv
// Shared types and constants for the Ethernet/IPv4 header parser.
package eihp_pkg;

    localparam int POSITION_BITS_DEF = 11;

    localparam logic [15:0] ETH_ARP      = 16'h0806;
    localparam logic [15:0] ETH_IPV4     = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP   = 8'd1;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [15:0] ARP_OP_REQ   = 16'h0001;
    localparam logic [15:0] ARP_OP_REPLY = 16'h0002;
    localparam logic [7:0]  ICMP_ECHO_REPLY = 8'd0;
    localparam logic [7:0]  ICMP_ECHO       = 8'd8;
    localparam logic [15:0] UDP_HDR_BYTES   = 16'd8;

    typedef enum logic [1:0] {
        FK_ARP   = 2'd0,
        FK_IPV4  = 2'd1,
        FK_OTHER = 2'd2
    } frame_kind_t;

    typedef enum logic [1:0] {
        L4_ICMP  = 2'd0,
        L4_TCP   = 2'd1,
        L4_UDP   = 2'd2,
        L4_OTHER = 2'd3
    } l4_kind_t;

    typedef enum logic [1:0] {
        ICMP_REPLY    = 2'd0,
        ICMP_REQUEST  = 2'd1,
        ICMP_OTHER    = 2'd2,
        ICMP_NONE     = 2'd3
    } icmp_kind_t;

    typedef enum logic [1:0] {
        ARP_REQUEST = 2'd0,
        ARP_REPLY   = 2'd1,
        ARP_UNKNOWN = 2'd2,
        ARP_NONE    = 2'd3
    } arp_op_kind_t;

    // Header fields captured so far in the current frame.
    typedef struct packed {
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] ether_type;
        logic [3:0]  ihl;
        logic [15:0] total_len;
        logic [7:0]  protocol;
        logic [3:0]  thl;
        logic [15:0] udp_len;
        logic [31:0] addr0;
        logic [31:0] addr1;
        logic [15:0] port0;
        logic [15:0] port1;
        logic [15:0] small_fields;   // [15:8] ICMP type, [7:0] TCP byte 13
    } cap_t;

    // One frame summary.
    typedef struct packed {
        frame_kind_t  frame_kind;
        logic [47:0]  dst_mac;
        logic [47:0]  src_mac;
        l4_kind_t     l4_kind;
        logic [31:0]  src_addr;
        logic [31:0]  dst_addr;
        logic [15:0]  src_port;
        logic [15:0]  dst_port;
        logic [5:0]   tcp_flags;
        icmp_kind_t   icmp_kind;
        arp_op_kind_t arp_op_kind;
        logic [15:0]  payload_length;
    } summary_t;

endpackage

FILE: design/eihp_byte_if.sv
// Byte stream channel: one frame byte and an end-of-frame mark per beat.
interface eihp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

FILE: design/eihp_summary_if.sv
// Summary channel: one parsed header summary per beat.
interface eihp_summary_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_kind;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [1:0]  l4_kind;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [5:0]  tcp_flags;
    logic [1:0]  icmp_kind;
    logic [1:0]  arp_op_kind;
    logic [15:0] payload_length;

    modport source (output valid, frame_kind, dst_mac, src_mac, l4_kind, src_addr,
                    dst_addr, src_port, dst_port, tcp_flags, icmp_kind, arp_op_kind,
                    payload_length, input ready);
    modport sink   (input valid, frame_kind, dst_mac, src_mac, l4_kind, src_addr,
                    dst_addr, src_port, dst_port, tcp_flags, icmp_kind, arp_op_kind,
                    payload_length, output ready);
endinterface

FILE: design/eihp_capture.sv
// Byte position counter and header field capture registers.
module eihp_capture #(
    parameter int POSITION_BITS = eihp_pkg::POSITION_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic [7:0]     data_byte,
    input  logic           last_byte,
    output eihp_pkg::cap_t cap_next
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    eihp_pkg::cap_t           cap_reg;

    logic [3:0]               ihl_eff;
    logic [POSITION_BITS-1:0] l4_base;
    logic [POSITION_BITS-1:0] l4_off;
    logic                     l4_in;

    // IHL written by byte 14 already places layer 4 for byte 14 itself.
    assign ihl_eff = (pos_reg == POSITION_BITS'(14)) ? data_byte[3:0] : cap_reg.ihl;
    assign l4_base = POSITION_BITS'(14) + POSITION_BITS'({ihl_eff, 2'b00});
    assign l4_in   = (pos_reg >= l4_base);
    assign l4_off  = pos_reg - l4_base;

    always_comb
    begin
        cap_next = cap_reg;
        if (pos_reg < POSITION_BITS'(6))
        begin
            cap_next.dst_mac = {cap_reg.dst_mac[39:0], data_byte};
        end
        else if (pos_reg < POSITION_BITS'(12))
        begin
            cap_next.src_mac = {cap_reg.src_mac[39:0], data_byte};
        end
        else if (pos_reg < POSITION_BITS'(14))
        begin
            cap_next.ether_type = {cap_reg.ether_type[7:0], data_byte};
        end
        else if (pos_reg != POS_MAX)
        begin
            if (cap_reg.ether_type == eihp_pkg::ETH_ARP)
            begin
                if (pos_reg == POSITION_BITS'(20) || pos_reg == POSITION_BITS'(21))
                begin
                    cap_next.port0 = {cap_reg.port0[7:0], data_byte};
                end
                if (pos_reg >= POSITION_BITS'(28) && pos_reg <= POSITION_BITS'(31))
                begin
                    cap_next.addr0 = {cap_reg.addr0[23:0], data_byte};
                end
                if (pos_reg >= POSITION_BITS'(38) && pos_reg <= POSITION_BITS'(41))
                begin
                    cap_next.addr1 = {cap_reg.addr1[23:0], data_byte};
                end
            end
            else if (cap_reg.ether_type == eihp_pkg::ETH_IPV4)
            begin
                if (pos_reg == POSITION_BITS'(14))
                begin
                    cap_next.ihl = ihl_eff;
                end
                if (pos_reg == POSITION_BITS'(16) || pos_reg == POSITION_BITS'(17))
                begin
                    cap_next.total_len = {cap_reg.total_len[7:0], data_byte};
                end
                if (pos_reg == POSITION_BITS'(23))
                begin
                    cap_next.protocol = data_byte;
                end
                if (pos_reg >= POSITION_BITS'(26) && pos_reg <= POSITION_BITS'(29))
                begin
                    cap_next.addr0 = {cap_reg.addr0[23:0], data_byte};
                end
                if (pos_reg >= POSITION_BITS'(30) && pos_reg <= POSITION_BITS'(33))
                begin
                    cap_next.addr1 = {cap_reg.addr1[23:0], data_byte};
                end
                // Layer-4 bytes, captured whatever the protocol.
                if (l4_in)
                begin
                    if (l4_off == POSITION_BITS'(0))
                    begin
                        cap_next.small_fields[15:8] = data_byte;
                    end
                    if (l4_off == POSITION_BITS'(0) || l4_off == POSITION_BITS'(1))
                    begin
                        cap_next.port0 = {cap_reg.port0[7:0], data_byte};
                    end
                    if (l4_off == POSITION_BITS'(2) || l4_off == POSITION_BITS'(3))
                    begin
                        cap_next.port1 = {cap_reg.port1[7:0], data_byte};
                    end
                    if (l4_off == POSITION_BITS'(4) || l4_off == POSITION_BITS'(5))
                    begin
                        cap_next.udp_len = {cap_reg.udp_len[7:0], data_byte};
                    end
                    if (l4_off == POSITION_BITS'(12))
                    begin
                        cap_next.thl = data_byte[7:4];
                    end
                    if (l4_off == POSITION_BITS'(13))
                    begin
                        cap_next.small_fields[7:0] = data_byte;
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (last_byte)
        begin
            pos_next = '0;
        end
        else if (pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + POSITION_BITS'(1);
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            cap_reg <= '0;
        end
        else if (step)
        begin
            pos_reg <= pos_next;
            cap_reg <= last_byte ? '0 : cap_next;
        end
    end

endmodule

FILE: design/eihp_summary.sv
// Frame summary decode from the captured header fields.
module eihp_summary (
    input  eihp_pkg::cap_t     cap,
    output eihp_pkg::summary_t res
);

    logic [16:0] tcp_hdr_bytes;
    logic [16:0] tcp_diff;
    logic [16:0] udp_diff;

    assign tcp_hdr_bytes = 17'({cap.ihl, 2'b00}) + 17'({cap.thl, 2'b00});
    assign tcp_diff      = {1'b0, cap.total_len} - tcp_hdr_bytes;
    assign udp_diff      = {1'b0, cap.udp_len} - {1'b0, eihp_pkg::UDP_HDR_BYTES};

    always_comb
    begin
        res                = '0;
        res.dst_mac        = cap.dst_mac;
        res.src_mac        = cap.src_mac;
        res.l4_kind        = eihp_pkg::L4_OTHER;
        res.icmp_kind      = eihp_pkg::ICMP_NONE;
        res.arp_op_kind    = eihp_pkg::ARP_NONE;

        if (cap.ether_type == eihp_pkg::ETH_ARP)
        begin
            res.frame_kind = eihp_pkg::FK_ARP;
            res.src_addr   = cap.addr0;
            res.dst_addr   = cap.addr1;
            if (cap.port0 == eihp_pkg::ARP_OP_REQ)
            begin
                res.arp_op_kind = eihp_pkg::ARP_REQUEST;
            end
            else if (cap.port0 == eihp_pkg::ARP_OP_REPLY)
            begin
                res.arp_op_kind = eihp_pkg::ARP_REPLY;
            end
            else
            begin
                res.arp_op_kind = eihp_pkg::ARP_UNKNOWN;
            end
        end
        else if (cap.ether_type == eihp_pkg::ETH_IPV4)
        begin
            res.frame_kind = eihp_pkg::FK_IPV4;
            res.src_addr   = cap.addr0;
            res.dst_addr   = cap.addr1;
            if (cap.protocol == eihp_pkg::PROTO_ICMP)
            begin
                res.l4_kind = eihp_pkg::L4_ICMP;
                if (cap.small_fields[15:8] == eihp_pkg::ICMP_ECHO_REPLY)
                begin
                    res.icmp_kind = eihp_pkg::ICMP_REPLY;
                end
                else if (cap.small_fields[15:8] == eihp_pkg::ICMP_ECHO)
                begin
                    res.icmp_kind = eihp_pkg::ICMP_REQUEST;
                end
                else
                begin
                    res.icmp_kind = eihp_pkg::ICMP_OTHER;
                end
            end
            else if (cap.protocol == eihp_pkg::PROTO_TCP)
            begin
                res.l4_kind   = eihp_pkg::L4_TCP;
                res.src_port  = cap.port0;
                res.dst_port  = cap.port1;
                res.tcp_flags = cap.small_fields[5:0];
                // Borrow out of the subtract means the header exceeds the length.
                res.payload_length = tcp_diff[16] ? 16'd0 : tcp_diff[15:0];
            end
            else if (cap.protocol == eihp_pkg::PROTO_UDP)
            begin
                res.l4_kind  = eihp_pkg::L4_UDP;
                res.src_port = cap.port0;
                res.dst_port = cap.port1;
                res.payload_length = udp_diff[16] ? 16'd0 : udp_diff[15:0];
            end
        end
        else
        begin
            res.frame_kind = eihp_pkg::FK_OTHER;
        end
    end

endmodule

FILE: design/ethernet_ipv4_header_parser.sv
// Ethernet/ARP/IPv4/TCP/UDP header parser, top level.
// Throughput: one frame byte per cycle; a closing byte waits in the input register while
// the previous summary is still untaken, which stalls the byte input.
// A closing byte passes through the input register, then the capture update and summary decode
// into the result register.
// Reset (rst_n, async, active low) clears the byte position, captured fields and valid flags.
`include "ethernet_ipv4_header_parser_defines.svh"

module ethernet_ipv4_header_parser #(
    parameter int POSITION_BITS = eihp_pkg::POSITION_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    eihp_byte_if.sink      frame,
    eihp_summary_if.source summary
);

    // Input register stage: holds one byte beat.
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Result register stage: holds one pending summary.
    logic               out_valid_reg;
    logic               out_valid_next;
    eihp_pkg::summary_t out_reg;

    eihp_pkg::cap_t     cap_next;
    eihp_pkg::summary_t sum_next;

    logic out_free;
    logic advance;
    logic emit;

    // A byte leaves the input register unless it closes a frame while an
    // untaken summary still occupies the result register.
    assign out_free = !out_valid_reg || summary.ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign emit     = advance && in_last_reg;

    assign frame.ready = !in_valid_reg || advance;

    eihp_capture #(
        .POSITION_BITS (POSITION_BITS)
    ) u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .cap_next  (cap_next)
    );

    // Decode from the fields as updated by the closing byte.
    eihp_summary u_summary (
        .cap (cap_next),
        .res (sum_next)
    );

    always_comb
    begin
        if (frame.valid && frame.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (summary.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            in_byte_reg <= frame.data_byte;
            in_last_reg <= frame.last_byte;
        end
        if (emit)
        begin
            out_reg <= sum_next;
        end
    end

    assign summary.valid          = out_valid_reg;
    assign summary.frame_kind     = out_reg.frame_kind;
    assign summary.dst_mac        = out_reg.dst_mac;
    assign summary.src_mac        = out_reg.src_mac;
    assign summary.l4_kind        = out_reg.l4_kind;
    assign summary.src_addr       = out_reg.src_addr;
    assign summary.dst_addr       = out_reg.dst_addr;
    assign summary.src_port       = out_reg.src_port;
    assign summary.dst_port       = out_reg.dst_port;
    assign summary.tcp_flags      = out_reg.tcp_flags;
    assign summary.icmp_kind      = out_reg.icmp_kind;
    assign summary.arp_op_kind    = out_reg.arp_op_kind;
    assign summary.payload_length = out_reg.payload_length;

    // A closing byte always produces a summary on the next cycle.
    `EIHP_ASSERT_NEXT(a_emit_shows, clk, rst_n, emit, out_valid_reg,
        "closing byte did not produce a summary")

    // A pending, untaken summary is never overwritten.
    `EIHP_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_reg && !summary.ready, !emit,
        "pending summary overwritten")

    // Frames of another ethertype carry no layer-3 or layer-4 content.
    `EIHP_ASSERT_NOW(a_other_empty, clk, rst_n,
        out_valid_reg && out_reg.frame_kind == eihp_pkg::FK_OTHER,
        out_reg.l4_kind == eihp_pkg::L4_OTHER && out_reg.src_addr == 32'd0 &&
        out_reg.arp_op_kind == eihp_pkg::ARP_NONE,
        "other-ethertype summary carries header content")

endmodule
